>>> rtl/rrss_pkg.sv
// Shared types and constants for the round robin slice scheduler.
// Used by rrss_grant and round_robin_slice_scheduler; depends on nothing.

package rrss_pkg;

   localparam int TIME_W    = 16;
   localparam int SLOT_W    = 4;
   localparam int PCOUNT_W  = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // request kinds carried on req_tuser
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SLICE = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_QUANTUM    = 1'b0;
   localparam logic REG_PROC_COUNT = 1'b1;

   localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd2;
   localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd0;

   // output of the shared compare/subtract unit
   typedef struct packed {
      logic              live;      // slot has time left
      logic [TIME_W-1:0] grant;     // min(remaining, quantum), zero quantum as 1
      logic [TIME_W-1:0] rest;      // remaining after the grant
      logic              finished;  // grant empties the slot
   } grant_type;

endpackage

>>> rtl/rrss_store.sv
// Remaining-time store: one write port, one registered read port.
// Valid bits make unwritten entries read as zero after reset. No package use.

module rrss_store #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rrss_grant.sv
// Shared compare/subtract unit: sizes one slice from a remaining time.
// Depends on rrss_pkg for grant_type and widths.

module rrss_grant (
   input  logic [rrss_pkg::TIME_W-1:0] remaining,
   input  logic [rrss_pkg::TIME_W-1:0] quantum,
   output rrss_pkg::grant_type         result
);

   logic [rrss_pkg::TIME_W-1:0] q_eff;
   logic [rrss_pkg::TIME_W:0]   diff;
   logic                        take_all;

   always_comb begin
      q_eff    = (quantum == '0) ? rrss_pkg::TIME_W'(1) : quantum;
      diff     = {1'b0, remaining} - {1'b0, q_eff};
      // borrow or zero difference: the whole remainder fits in one slice
      take_all = diff[rrss_pkg::TIME_W] || (diff == '0);
      result.live     = (remaining != '0);
      result.grant    = take_all ? remaining : q_eff;
      result.rest     = take_all ? '0 : diff[rrss_pkg::TIME_W-1:0];
      result.finished = take_all;
   end

endmodule

>>> rtl/round_robin_slice_scheduler.sv
// Round robin slice scheduler top level: config registers, scan sequencer
// and result register. Uses rrss_pkg, rrss_store and rrss_grant.
//
//   channel  | ports          | carries
//   ---------+----------------+----------------------------------------------
//   request  | req_t*         | tuser: kind; tdata: slot, burst time
//   response | rsp_t*         | tdata: proc id, run time, finished, all done
//   config   | csr_p*         | quantum at 0x0, process count at 0x4
//
// A load is written into the store when accepted. A slice reads the slots in
// use in turn through the single store read port, stops at the first with
// time left and hands its result to the output register. Reset is synchronous
// and clears the store valid bits at once, so no clearing pass is needed.
// req_tready is low while a slice is scanned or its result waits in ST_POST.

module round_robin_slice_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = req_type; tdata = slot[3:0], burst_time[19:4], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,
   input  logic [rrss_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: tdata = proc_id[3:0], run_time[19:4], finished[20],
   //           all_done[21], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rrss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rrss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rrss_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rrss_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   state_type                     state_ff;
   logic [rrss_pkg::TIME_W-1:0]   quantum_ff;
   logic [rrss_pkg::PCOUNT_W-1:0] pcount_ff;
   logic [IDX_W-1:0]              scan_pos_ff;
   logic [IDX_W-1:0]              cur_ff;
   logic [CNT_W-1:0]              count_ff;

   logic [rrss_pkg::SLOT_W-1:0]   res_proc_ff;
   logic [rrss_pkg::TIME_W-1:0]   res_run_ff;
   logic                          res_fin_ff;
   logic                          res_done_ff;

   logic                          rsp_valid_ff;
   logic [rrss_pkg::SLOT_W-1:0]   rsp_proc_ff;
   logic [rrss_pkg::TIME_W-1:0]   rsp_run_ff;
   logic                          rsp_fin_ff;
   logic                          rsp_done_ff;

   logic                          csr_write;
   logic                          req_fire;
   logic                          req_load;
   logic [rrss_pkg::SLOT_W-1:0]   req_slot;
   logic [rrss_pkg::TIME_W-1:0]   req_burst;
   logic                          slot_ok;
   logic [CNT_W-1:0]              used;
   logic [IDX_W-1:0]              start;
   logic [CNT_W-1:0]              cur_plus;
   logic [IDX_W-1:0]              cur_next;
   logic                          out_free;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [rrss_pkg::TIME_W-1:0]   wr_data;
   logic [IDX_W-1:0]              rd_addr;
   logic [rrss_pkg::TIME_W-1:0]   rd_data;
   rrss_pkg::grant_type           grant;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrss_pkg::QUANTUM_RESET;
         pcount_ff  <= rrss_pkg::PCOUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            rrss_pkg::REG_QUANTUM: begin
               quantum_ff <= csr_pwdata[rrss_pkg::TIME_W-1:0];
            end
            rrss_pkg::REG_PROC_COUNT: begin
               pcount_ff <= csr_pwdata[rrss_pkg::PCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rrss_pkg::REG_QUANTUM:    csr_prdata = rrss_pkg::CSR_DATA_W'(quantum_ff);
         rrss_pkg::REG_PROC_COUNT: csr_prdata = rrss_pkg::CSR_DATA_W'(pcount_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------- request decode ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_load   = (req_tuser == rrss_pkg::REQ_LOAD);
   assign req_slot   = req_tdata[rrss_pkg::SLOT_W-1:0];
   assign req_burst  = req_tdata[rrss_pkg::SLOT_W +: rrss_pkg::TIME_W];
   assign slot_ok    = 32'(req_slot) < 32'(MAX_PROCS);

   always_comb begin
      used     = (32'(pcount_ff) > 32'(MAX_PROCS)) ? CNT_W'(MAX_PROCS)
                                                   : CNT_W'(pcount_ff);
      start    = (CNT_W'(scan_pos_ff) < used) ? scan_pos_ff : '0;
      cur_plus = CNT_W'(cur_ff) + CNT_W'(1);
      cur_next = (cur_plus < used) ? cur_plus[IDX_W-1:0] : '0;
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // ---------------- store and shared unit ----------------
   always_comb begin
      if (state_ff == ST_IDLE) begin
         wr_en   = req_fire && req_load && slot_ok;
         wr_addr = IDX_W'(req_slot);
         wr_data = req_burst;
         rd_addr = start;
      end else begin
         wr_en   = (state_ff == ST_SCAN) && grant.live;
         wr_addr = cur_ff;
         wr_data = grant.rest;
         rd_addr = cur_next;
      end
   end

   rrss_store #(
      .DEPTH  (MAX_PROCS),
      .DATA_W (rrss_pkg::TIME_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rrss_grant u_grant (
      .remaining (rd_data),
      .quantum   (quantum_ff),
      .result    (grant)
   );

   // ---------------- sequencer and result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_POST the output register is either reloaded below or held full
         if (rsp_valid_ff && rsp_tready && state_ff != ST_POST) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_load) begin
                     scan_pos_ff <= '0;
                  end else if (used == '0) begin
                     // nothing in use: report all done at once
                     scan_pos_ff <= '0;
                     res_proc_ff <= '0;
                     res_run_ff  <= '0;
                     res_fin_ff  <= 1'b0;
                     res_done_ff <= 1'b1;
                     state_ff    <= ST_POST;
                  end else begin
                     cur_ff   <= start;
                     count_ff <= '0;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (grant.live) begin
                  scan_pos_ff <= cur_next;
                  res_proc_ff <= rrss_pkg::SLOT_W'(cur_ff);
                  res_run_ff  <= grant.grant;
                  res_fin_ff  <= grant.finished;
                  res_done_ff <= 1'b0;
                  state_ff    <= ST_POST;
               end else if (count_ff + CNT_W'(1) == used) begin
                  scan_pos_ff <= '0;
                  res_proc_ff <= '0;
                  res_run_ff  <= '0;
                  res_fin_ff  <= 1'b0;
                  res_done_ff <= 1'b1;
                  state_ff    <= ST_POST;
               end else begin
                  // advance to the next slot, its read is already issued
                  cur_ff   <= cur_next;
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_POST: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_proc_ff  <= res_proc_ff;
                  rsp_run_ff   <= res_run_ff;
                  rsp_fin_ff   <= res_fin_ff;
                  rsp_done_ff  <= res_done_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_done_ff, rsp_fin_ff, rsp_run_ff, rsp_proc_ff};

`ifndef SYNTHESIS
   a_post_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && !out_free) |=> (state_ff == ST_POST))
      else $error("result lost while output register full");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_run_ff == '0 && !rsp_fin_ff))
      else $error("all done result carries a slice");

   a_grant_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |->
      (rsp_run_ff != '0 && (rsp_run_ff <= quantum_ff || quantum_ff == '0)))
      else $error("granted slice empty or above quantum");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff < used && CNT_W'(cur_ff) < used))
      else $error("scan ran past the slots in use");
`endif

endmodule

>>> tb/round_robin_slice_scheduler_tb.sv
// Self-checking testbench for round_robin_slice_scheduler: stream driver, response
// monitor with a built-in slice predictor, and APB register setup between phases.
// Depends on rrss_pkg and the round_robin_slice_scheduler RTL.

module round_robin_slice_scheduler_tb;

   localparam int          MAX_PROCS    = 16;
   localparam int          SETTLE_CYC   = 24;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RAND_PHASES  = 12;
   localparam int          PHASE_ITEMS  = 142;

   localparam int          SLOT_W       = rrss_pkg::SLOT_W;
   localparam int          TIME_W       = rrss_pkg::TIME_W;
   localparam int          PCOUNT_W     = rrss_pkg::PCOUNT_W;
   localparam int          REQ_DATA_W   = rrss_pkg::REQ_DATA_W;
   localparam int          RSP_DATA_W   = rrss_pkg::RSP_DATA_W;
   localparam int          CSR_ADDR_W   = rrss_pkg::CSR_ADDR_W;
   localparam int          CSR_DATA_W   = rrss_pkg::CSR_DATA_W;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] burst;
      logic              drain;
   } sched_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] proc_id;
      logic [TIME_W-1:0] run_time;
      logic              finished;
      logic              all_done;
   } slice_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = rrss_pkg::REQ_LOAD;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [TIME_W-1:0]     time_left [MAX_PROCS];
   int unsigned           scan_pos;
   logic [TIME_W-1:0]     cur_quantum;
   logic [PCOUNT_W-1:0]   cur_pcount;

   sched_req_type         pending_reqs[$];
   slice_type             expected_slices[$];
   logic                  req_taken = 1'b0;
   int unsigned           send_idle_pct = 31;
   int unsigned           recv_idle_pct = 84;
   int unsigned           cycle_count = 0;
   int unsigned           fail_count = 0;

   round_robin_slice_scheduler #(.MAX_PROCS(MAX_PROCS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("round_robin_slice_scheduler test failed");
         $finish;
      end
   end

   // Grant the next slice from the predictor's table and advance the scan.
   function automatic slice_type predict_slice();
      slice_type         res;
      int unsigned       used;
      int unsigned       first;
      int unsigned       idx;
      int unsigned       q;
      int unsigned       k;
      logic [TIME_W-1:0] take;
      res = '0;
      res.all_done = 1'b1;
      used = (cur_pcount > MAX_PROCS) ? MAX_PROCS : cur_pcount;
      first = (scan_pos < used) ? scan_pos : 0;
      q = (cur_quantum == 0) ? 1 : cur_quantum;
      for (k = 0; k < used; k++) begin
         idx = (first + k) % used;
         if (time_left[idx] != 0) begin
            take = (time_left[idx] > q) ? q[TIME_W-1:0] : time_left[idx];
            time_left[idx] = time_left[idx] - take;
            scan_pos = (idx + 1 < used) ? idx + 1 : 0;
            res.proc_id = idx[SLOT_W-1:0];
            res.run_time = take;
            res.finished = (time_left[idx] == 0);
            res.all_done = 1'b0;
            return res;
         end
      end
      scan_pos = 0;
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      sched_req_type nxt;
      logic          hold;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            hold = pending_reqs.size() == 0;
            if (!hold)
               hold = pending_reqs[0].drain && expected_slices.size() != 0;
            if (!hold && $urandom_range(99, 0) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.kind;
               req_tdata  <= {{(REQ_DATA_W-TIME_W-SLOT_W){1'b0}}, nxt.burst, nxt.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // response monitor and predictor update
   always @(posedge clock) begin
      slice_type got;
      slice_type want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.proc_id  = rsp_tdata[SLOT_W-1:0];
            got.run_time = rsp_tdata[SLOT_W +: TIME_W];
            got.finished = rsp_tdata[SLOT_W+TIME_W];
            got.all_done = rsp_tdata[SLOT_W+TIME_W+1];
            if (expected_slices.size() == 0) begin
               $error("response transfer with no slice expected: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_slices.pop_front();
               if (got.proc_id !== want.proc_id) begin
                  $error("proc_id expected %0d got %0d", want.proc_id, got.proc_id);
                  fail_count++;
               end
               if (got.run_time !== want.run_time) begin
                  $error("run_time expected %0d got %0d", want.run_time, got.run_time);
                  fail_count++;
               end
               if (got.finished !== want.finished) begin
                  $error("finished expected %0b got %0b", want.finished, got.finished);
                  fail_count++;
               end
               if (got.all_done !== want.all_done) begin
                  $error("all_done expected %0b got %0b", want.all_done, got.all_done);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == rrss_pkg::REQ_LOAD) begin
               time_left[req_tdata[SLOT_W-1:0]] = req_tdata[SLOT_W +: TIME_W];
               scan_pos = 0;
            end else begin
               expected_slices.push_back(predict_slice());
            end
         end
      end
   end

   task automatic add_req(input logic kind, input int unsigned slot,
                          input int unsigned burst, input logic drain);
      sched_req_type r;
      r.kind  = kind;
      r.slot  = slot[SLOT_W-1:0];
      r.burst = burst[TIME_W-1:0];
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   task automatic apb_cycle(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write one register, read it back and mirror it into the predictor.
   task automatic set_register(input logic index, input int unsigned value);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] mask;
      addr = {index, 2'b00};
      mask = (index == rrss_pkg::REG_QUANTUM) ? 32'h0000_FFFF : 32'h0000_001F;
      apb_cycle(1'b1, addr, value, rdata);
      apb_cycle(1'b0, addr, '0, rdata);
      if ((rdata & mask) !== (value & mask)) begin
         $error("register %0d expected %0d got %0d", index, value & mask, rdata & mask);
         fail_count++;
      end
      if (index == rrss_pkg::REG_QUANTUM)
         cur_quantum = value[TIME_W-1:0];
      else
         cur_pcount = value[PCOUNT_W-1:0];
   endtask

   // Wait until every transfer is done and the block has finished any load.
   task automatic settle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_slices.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      int unsigned q_tab [RAND_PHASES];
      int unsigned pc_tab [RAND_PHASES];
      int unsigned p;
      int unsigned n;
      int unsigned i;
      int unsigned used;
      int unsigned qe;
      int unsigned need;
      int unsigned nslices;
      int unsigned slot;
      int unsigned burst;
      int unsigned seq_no;
      int unsigned r;
      q_tab  = '{1, 65535, 2, 3, 5, 1, 16, 4, 100, 2, 7, 1};
      pc_tab = '{16, 1, 2, 16, 5, 3, 31, 8, 16, 0, 12, 16};
      for (i = 0; i < MAX_PROCS; i++) time_left[i] = '0;
      scan_pos    = 0;
      cur_quantum = rrss_pkg::QUANTUM_RESET;
      cur_pcount  = rrss_pkg::PCOUNT_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: no slot in use, so every slice reports all done
      add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      add_req(rrss_pkg::REQ_LOAD, 0, 4, 1'b0);
      add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      settle();

      // quantum of zero grants one unit; wrap between the first and last slot
      set_register(rrss_pkg::REG_QUANTUM, 0);
      set_register(rrss_pkg::REG_PROC_COUNT, 16);
      add_req(rrss_pkg::REQ_LOAD, 15, 65535, 1'b0);
      add_req(rrss_pkg::REQ_LOAD, 0, 2, 1'b0);
      repeat (4) add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      add_req(rrss_pkg::REQ_LOAD, 15, 0, 1'b0);
      add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      settle();

      // largest quantum, slot count above the table size
      set_register(rrss_pkg::REG_QUANTUM, 65535);
      set_register(rrss_pkg::REG_PROC_COUNT, 31);
      add_req(rrss_pkg::REQ_LOAD, 7, 65535, 1'b0);
      add_req(rrss_pkg::REQ_LOAD, 12, 65535, 1'b0);
      repeat (3) add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      settle();

      // leave the scan past slot 3, then shrink the slots in use
      set_register(rrss_pkg::REG_QUANTUM, 3);
      set_register(rrss_pkg::REG_PROC_COUNT, 16);
      add_req(rrss_pkg::REQ_LOAD, 1, 5, 1'b0);
      add_req(rrss_pkg::REQ_LOAD, 10, 1, 1'b0);
      repeat (2) add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      settle();
      set_register(rrss_pkg::REG_PROC_COUNT, 4);
      repeat (2) add_req(rrss_pkg::REQ_SLICE, 0, 0, 1'b0);
      settle();

      for (p = 0; p < RAND_PHASES; p++) begin
         if (p >= 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (p >= 4) begin
            send_idle_pct = 84;
            recv_idle_pct = 31;
         end
         set_register(rrss_pkg::REG_QUANTUM,
                      (p % 4 == 3) ? $urandom_range(40, 1) : q_tab[p]);
         set_register(rrss_pkg::REG_PROC_COUNT, pc_tab[p]);
         used = (cur_pcount > MAX_PROCS) ? MAX_PROCS : cur_pcount;
         qe = (cur_quantum == 0) ? 1 : cur_quantum;
         n = 0;
         seq_no = 0;
         // well-formed runs: load slots, then ask for slices, mostly enough to drain them
         while (n < PHASE_ITEMS) begin
            need = 0;
            r = $urandom_range(6, 1);
            for (i = 0; i < r; i++) begin
               if (used != 0 && $urandom_range(4, 0) != 0)
                  slot = $urandom_range(used - 1, 0);
               else
                  slot = $urandom_range(15, 0);
               case ($urandom_range(15, 0))
                  0: burst = 0;
                  1: burst = (qe > 255) ? $urandom_range(65535, 0) : 1;
                  default: burst = $urandom_range((qe * 4 > 65535) ? 65535 : qe * 4, 1);
               endcase
               need += ((burst + qe - 1) / qe > 30) ? 30 : (burst + qe - 1) / qe;
               add_req(rrss_pkg::REQ_LOAD, slot, burst,
                       (i == 0) && (seq_no == 2 || $urandom_range(19, 0) == 0));
               n++;
            end
            if ($urandom_range(3, 0) == 0)
               nslices = $urandom_range(8, 1);
            else
               nslices = (need + 3 > 40) ? 40 : need + $urandom_range(3, 0);
            for (i = 0; i < nslices; i++) begin
               // stray load in the middle of a run restarts the scan
               if ($urandom_range(14, 0) == 0) begin
                  add_req(rrss_pkg::REQ_LOAD, $urandom_range(15, 0),
                          $urandom_range(65535, 0), 1'b0);
                  n++;
               end
               add_req(rrss_pkg::REQ_SLICE, $urandom_range(15, 0),
                       $urandom_range(65535, 0), 1'b0);
               n++;
            end
            seq_no++;
         end
         settle();
      end

      if (fail_count == 0)
         $display("round_robin_slice_scheduler test passed");
      else
         $display("round_robin_slice_scheduler test failed");
      $finish;
   end

endmodule
